// ===== hw/rtl/tcfd_pkg.sv =====
// shared constants, command codes and the float conversion for the frame decoder
package tcfd_pkg;

    localparam int REPEAT_NEEDED = 6;

    localparam int CMD_W    = 6;
    localparam int REPEAT_W = 3;
    localparam int LEVEL_W  = 8;
    localparam int THR_W    = 15;
    localparam int TONE_W   = 3;
    localparam int VAL_W    = 17;

    localparam logic [CMD_W-1:0] CMD_LAST      = 6'd47;
    localparam logic [CMD_W-1:0] CMD_BEACON_1  = 6'd1;
    localparam logic [CMD_W-1:0] CMD_BEACON_2  = 6'd2;
    localparam logic [CMD_W-1:0] CMD_BEACON_3  = 6'd3;
    localparam logic [CMD_W-1:0] CMD_BEACON_4  = 6'd4;
    localparam logic [CMD_W-1:0] CMD_BEACON_5  = 6'd5;
    localparam logic [CMD_W-1:0] CMD_DIR_NORM  = 6'd7;
    localparam logic [CMD_W-1:0] CMD_DIR_REV   = 6'd8;
    localparam logic [CMD_W-1:0] CMD_BIDIR_OFF = 6'd9;
    localparam logic [CMD_W-1:0] CMD_BIDIR_ON  = 6'd10;
    localparam logic [CMD_W-1:0] CMD_SAVE      = 6'd12;
    localparam logic [CMD_W-1:0] CMD_TLM_ARM   = 6'd13;
    localparam logic [CMD_W-1:0] CMD_SPIN_FWD  = 6'd20;
    localparam logic [CMD_W-1:0] CMD_SPIN_REV  = 6'd21;
    localparam logic [CMD_W-1:0] CMD_PROGRAM   = 6'd36;

    localparam logic [LEVEL_W-1:0] LEVEL_LIMIT = 8'd100;

    localparam logic [0:0] REG_ARM_ENABLE = 1'b0;

    // ieee single to int16, truncate toward zero, saturate, nan gives zero
    function automatic logic signed [VAL_W-1:0] float_to_i16(input logic [31:0] bits);
        logic [7:0]        expo;
        logic [22:0]       mant;
        logic              neg;
        logic [7:0]        unb;
        logic [4:0]        rsh;
        logic [23:0]       sig;
        logic [THR_W-1:0]  mag;
        logic [VAL_W-1:0]  res;
        expo = bits[30:23];
        mant = bits[22:0];
        neg  = bits[31];
        unb  = expo - 8'd127;
        rsh  = 5'd23 - {1'b0, unb[3:0]};
        sig  = {1'b1, mant} >> rsh;
        mag  = sig[THR_W-1:0];
        if (expo == 8'hFF && mant != 23'd0) begin
            res = '0;
        end else if (expo < 8'd127) begin
            res = '0;
        end else if (unb >= 8'd15) begin
            res = neg ? 17'h18000 : 17'h07FFF;
        end else begin
            res = neg ? (17'd0 - {2'b00, mag}) : {2'b00, mag};
        end
        return $signed(res);
    endfunction

endpackage

// ===== hw/rtl/throttle_command_frame_decoder.sv =====
// throttle and command frame decoder: float decode, command repeat logic, apb setting
//
//  channel | direction | ports                          | handshake
//  --------+-----------+--------------------------------+----------------------------
//  frames  | in        | s_payload_bits .. s_telemetry_ | s_valid / s_ready
//  results | out       | m_throttle_value .. m_frame_good| m_valid / m_ready
//  config  | in        | psel penable pwrite paddr ...  | apb, pready tied high
//
// one frame per cycle: the float decode and the command update run in a single
// pass from the input ports into the result register and the state registers
// a new request is taken in every cycle while the result register is empty or
// being drained in that same cycle; the result stays put while m_ready is low
// reset (aresetn low, synchronous) clears all state, the result valid flag and
// the arm-enable setting; drive direction resets to forward
module throttle_command_frame_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    // frame request
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [31:0]                 s_payload_bits,
    input  logic                        s_telemetry_bit,
    input  logic                        s_frame_error,
    input  logic                        s_line_high,
    input  logic                        s_motor_armed,
    input  logic                        s_motor_running,
    input  logic                        s_telemetry_pending,
    // result request
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tcfd_pkg::THR_W-1:0]  m_throttle_value,
    output logic                        m_throttle_update,
    output logic [tcfd_pkg::TONE_W-1:0] m_tone_code,
    output logic                        m_forward_dir,
    output logic                        m_reversed_setting,
    output logic                        m_bidirectional_setting,
    output logic                        m_save_request,
    output logic                        m_programming_active,
    output logic                        m_telemetry_armed,
    output logic                        m_telemetry_request,
    output logic                        m_frame_good,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tcfd_pkg::*;

    // setting
    logic arm_enable_reg;

    // decoder state
    logic [CMD_W-1:0]    pending_reg,   pending_next;
    logic [CMD_W-1:0]    previous_reg,  previous_next;
    logic [REPEAT_W-1:0] repeat_reg,    repeat_next;
    logic [LEVEL_W-1:0]  level_reg,     level_next;
    logic                tlm_armed_reg, tlm_armed_next;
    logic                reversed_reg,  reversed_next;
    logic                bidir_reg,     bidir_next;
    logic                forward_reg,   forward_next;
    logic                program_reg,   program_next;

    // result register
    logic                m_valid_reg;
    logic [THR_W-1:0]    thr_reg,    thr_next;
    logic                upd_reg,    upd_next;
    logic [TONE_W-1:0]   tone_reg,   tone_next;
    logic                save_reg,   save_next;
    logic                treq_reg,   treq_next;
    logic                good_reg,   good_next;

    logic                   accept;
    logic signed [VAL_W-1:0] value;
    logic                   thr_ok;
    logic                   is_cmd;
    logic [REPEAT_W:0]      cnt;
    logic                   cfg_write;
    logic                   cfg_hit;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign value   = float_to_i16(s_payload_bits);

    // apb: one register at byte address 0, low address bits ignored
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == REG_ARM_ENABLE);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign prdata    = cfg_hit ? {31'd0, arm_enable_reg} : 32'd0;

    always_comb begin
        pending_next   = pending_reg;
        previous_next  = previous_reg;
        repeat_next    = repeat_reg;
        level_next     = level_reg;
        tlm_armed_next = tlm_armed_reg;
        reversed_next  = reversed_reg;
        bidir_next     = bidir_reg;
        forward_next   = forward_reg;
        program_next   = program_reg;
        thr_next       = '0;
        upd_next       = 1'b0;
        tone_next      = '0;
        save_next      = 1'b0;
        treq_next      = 1'b0;
        good_next      = 1'b0;
        thr_ok         = 1'b0;
        is_cmd         = 1'b0;
        cnt            = '0;

        // line level counting runs for every frame, good or bad
        if (!s_motor_armed && !s_telemetry_pending && s_line_high) begin
            level_next = level_reg + 1'b1;
            if (level_next > LEVEL_LIMIT) begin
                treq_next = 1'b1;
            end
        end

        if (!s_frame_error) begin
            good_next = 1'b1;
            if (s_telemetry_bit) begin
                treq_next = 1'b1;
            end
            thr_ok = (value > $signed({11'd0, CMD_LAST}))
                     && (tlm_armed_reg || !arm_enable_reg);
            is_cmd = (value > $signed(17'sd0)) && (value <= $signed({11'd0, CMD_LAST}));

            if (thr_ok) begin
                thr_next     = value[THR_W-1:0];
                upd_next     = 1'b1;
                pending_next = '0;
                repeat_next  = '0;
            end else if (is_cmd) begin
                upd_next     = 1'b1;
                pending_next = value[CMD_W-1:0];
            end else if (value == '0) begin
                if (arm_enable_reg) begin
                    tlm_armed_next = 1'b0;
                end
                upd_next     = 1'b1;
                pending_next = '0;
                repeat_next  = '0;
            end

            // commands only run on an armed, stopped motor
            if (!thr_ok && pending_next != '0 && !s_motor_running && s_motor_armed) begin
                if (pending_next != previous_reg) begin
                    previous_next = pending_next;
                    repeat_next   = '0;
                end
                cnt = {1'b0, repeat_next} + 1'b1;
                // beacons 1 to 4 fire at once, beacon 5 and everything else need repeats
                if (pending_next < CMD_BEACON_5
                        || cnt >= (REPEAT_W+1)'(REPEAT_NEEDED)) begin
                    repeat_next = '0;
                    unique case (pending_next)
                        CMD_BEACON_1, CMD_BEACON_2, CMD_BEACON_3,
                        CMD_BEACON_4, CMD_BEACON_5: begin
                            tone_next = pending_next[TONE_W-1:0];
                        end
                        CMD_DIR_NORM: begin
                            reversed_next = 1'b0;
                            forward_next  = 1'b1;
                        end
                        CMD_DIR_REV: begin
                            reversed_next = 1'b1;
                            forward_next  = 1'b0;
                        end
                        CMD_BIDIR_OFF: begin
                            bidir_next = 1'b0;
                        end
                        CMD_BIDIR_ON: begin
                            bidir_next = 1'b1;
                        end
                        CMD_SAVE: begin
                            // confirmation tone tells which direction got saved
                            save_next = 1'b1;
                            tone_next = {2'b00, reversed_reg} + 3'd1;
                        end
                        CMD_TLM_ARM: begin
                            if (arm_enable_reg) begin
                                tlm_armed_next = 1'b1;
                            end
                        end
                        CMD_SPIN_FWD: begin
                            forward_next = !reversed_reg;
                        end
                        CMD_SPIN_REV: begin
                            forward_next = reversed_reg;
                        end
                        CMD_PROGRAM: begin
                            program_next = 1'b1;
                        end
                        default: begin
                            // unknown codes are just dropped from pending
                        end
                    endcase
                    pending_next = '0;
                end else begin
                    repeat_next = cnt[REPEAT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_enable_reg <= 1'b0;
            pending_reg    <= '0;
            previous_reg   <= '0;
            repeat_reg     <= '0;
            level_reg      <= '0;
            tlm_armed_reg  <= 1'b0;
            reversed_reg   <= 1'b0;
            bidir_reg      <= 1'b0;
            forward_reg    <= 1'b1;
            program_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                arm_enable_reg <= pwdata[0];
            end
            if (accept) begin
                pending_reg   <= pending_next;
                previous_reg  <= previous_next;
                repeat_reg    <= repeat_next;
                level_reg     <= level_next;
                tlm_armed_reg <= tlm_armed_next;
                reversed_reg  <= reversed_next;
                bidir_reg     <= bidir_next;
                forward_reg   <= forward_next;
                program_reg   <= program_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-frame result fields, no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            thr_reg  <= thr_next;
            upd_reg  <= upd_next;
            tone_reg <= tone_next;
            save_reg <= save_next;
            treq_reg <= treq_next;
            good_reg <= good_next;
        end
    end

    // settings live in the state registers, which only move on an accepted frame
    assign m_valid                 = m_valid_reg;
    assign m_throttle_value        = thr_reg;
    assign m_throttle_update       = upd_reg;
    assign m_tone_code             = tone_reg;
    assign m_forward_dir           = forward_reg;
    assign m_reversed_setting      = reversed_reg;
    assign m_bidirectional_setting = bidir_reg;
    assign m_save_request          = save_reg;
    assign m_programming_active    = program_reg;
    assign m_telemetry_armed       = tlm_armed_reg;
    assign m_telemetry_request     = treq_reg;
    assign m_frame_good            = good_reg;

    // a nonzero throttle only comes out of a good frame flagged for update
    a_thr_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_throttle_value != '0 |-> m_throttle_update && m_frame_good)
        else $error("throttle value without update on a good frame");

    // a save always carries one of the two direction tones
    a_save_tone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_save_request |-> m_tone_code == 3'd1 || m_tone_code == 3'd2)
        else $error("save request without confirmation tone");

    // a bad frame produces no throttle, tone or save
    a_bad_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_frame_error |=> !m_frame_good && !m_throttle_update
            && m_tone_code == '0 && !m_save_request)
        else $error("discarded frame had an effect");

    // settings do not move without an accepted frame
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(m_forward_dir) && $stable(m_reversed_setting)
            && $stable(m_bidirectional_setting) && $stable(m_programming_active))
        else $error("setting changed without a frame");

endmodule
